### hw/rtl/gcdb_pkg.sv
// ----------------------------------------------------------------------------
// gcdb_pkg
// shared widths, fixed-point constants and helpers for the great-circle
// distance and bearing core
// ----------------------------------------------------------------------------
`default_nettype none

package gcdb_pkg;

  localparam int FRAC_BITS_DEF    = 22;
  localparam int CORDIC_STEPS_DEF = 24;
  localparam int ATAN_ENTRIES     = 32;
  localparam int SQRT_STEPS       = 32;

  // angle width before reduction, cordic datapath width, product width
  localparam int AW  = 38;
  localparam int CW  = 36;
  localparam int QW  = 34;
  localparam int SQW = 63;

  localparam logic signed [AW-1:0] PI_Q      = 38'sd3373259426;
  localparam logic signed [AW-1:0] HALF_PI_Q = 38'sd1686629713;
  localparam logic signed [AW-1:0] TWO_PI_Q  = 38'sd6746518852;
  localparam logic signed [AW-1:0] FOUR_PI_Q = 38'sd13493037704;
  localparam logic signed [CW-1:0] PI_C      = 36'sd3373259426;
  localparam logic signed [CW-1:0] GAIN_K    = 36'sd652032874;
  localparam logic signed [27:0]   DEG2RAD_Q = 28'sd74961321;
  localparam logic signed [30:0]   RAD2DEG_Q = 31'sd961263669;
  localparam logic signed [23:0]   EARTH_R_M = 24'sd6371100;
  localparam logic [30:0]          ONE_Q     = 31'd1073741824;
  localparam logic [24:0]          DIST_MAX  = 25'd20015400;
  localparam logic signed [24:0]   BRG_MAX   = 25'sd11796480;

  localparam logic [31:0] ATAN_TAB [ATAN_ENTRIES] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
    32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
    32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
    32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
    32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
    32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
    32'h00000001, 32'h00000000
  };

  typedef struct packed {
    logic [7:0]         bearing_code;
    logic signed [24:0] bearing_deg;
    logic [24:0]        distance_m;
  } res_t;

  // q30 product, floor shift
  function automatic logic signed [QW-1:0] mulq(input logic signed [QW-1:0] a,
                                                input logic signed [QW-1:0] b);
    logic signed [2*QW-1:0] p;
    p = a * b;
    return QW'(p >>> 30);
  endfunction

  // whole degrees onto the byte scale, 128*w/180 by reciprocal (w <= 180)
  function automatic logic [7:0] code_of(input logic signed [24:0] deg);
    logic [24:0] mag;
    logic [7:0]  whole;
    logic [20:0] prod;
    logic [7:0]  q;
    mag   = deg[24] ? 25'(-deg) : 25'(deg);
    whole = mag[23:16];
    prod  = 21'(whole) * 21'd5826;
    q     = prod[20:13];
    return deg[24] ? (8'd255 - q) : q;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/gcdb_cordic.sv
// ----------------------------------------------------------------------------
// gcdb_cordic
// unrolled cordic, one registered stage per iteration, rotation or vectoring
// ----------------------------------------------------------------------------
`default_nettype none

module gcdb_cordic
  import gcdb_pkg::*;
#(
  parameter int W         = CW,
  parameter int STEPS     = CORDIC_STEPS_DEF,
  parameter bit VECTORING = 1'b0,
  parameter int SW        = 1
) (
  input  wire logic                clk,
  input  wire logic                en,
  input  wire logic signed [W-1:0] x_in,
  input  wire logic signed [W-1:0] y_in,
  input  wire logic signed [W-1:0] z_in,
  input  wire logic [SW-1:0]       side_in,
  output logic signed [W-1:0]      x_out,
  output logic signed [W-1:0]      y_out,
  output logic signed [W-1:0]      z_out,
  output logic [SW-1:0]            side_out
);

  logic signed [W-1:0] x_r [STEPS];
  logic signed [W-1:0] y_r [STEPS];
  logic signed [W-1:0] z_r [STEPS];
  logic [SW-1:0]       side_r [STEPS];

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    logic signed [W-1:0] xs, ys, zs, dx, dy, at;
    logic [SW-1:0]       ss;
    logic                dpos;

    if (i == 0) begin : g_first
      assign xs = x_in;
      assign ys = y_in;
      assign zs = z_in;
      assign ss = side_in;
    end else begin : g_next
      assign xs = x_r[i-1];
      assign ys = y_r[i-1];
      assign zs = z_r[i-1];
      assign ss = side_r[i-1];
    end

    assign dx = ys >>> i;
    assign dy = xs >>> i;
    assign at = $signed(W'(ATAN_TAB[i]));
    // rotation steers by the residual angle, vectoring by the sign of y
    assign dpos = VECTORING ? ys[W-1] : !zs[W-1];

    always_ff @(posedge clk) begin
      if (en) begin
        x_r[i]    <= dpos ? xs - dx : xs + dx;
        y_r[i]    <= dpos ? ys + dy : ys - dy;
        z_r[i]    <= dpos ? zs - at : zs + at;
        side_r[i] <= ss;
      end
    end
  end

  assign x_out    = x_r[STEPS-1];
  assign y_out    = y_r[STEPS-1];
  assign z_out    = z_r[STEPS-1];
  assign side_out = side_r[STEPS-1];

endmodule

`default_nettype wire

### hw/rtl/great_circle_distance_bearing_core.sv
// ----------------------------------------------------------------------------
// great_circle_distance_bearing_core
// haversine distance and initial bearing between two points, fully pipelined
// ----------------------------------------------------------------------------
// Takes one start/destination pair per clock and returns the distance in
// meters, the initial bearing in degrees Q8.16 and a byte bearing code. The
// pipeline runs angle conversion and reduction, the unrolled rotation cordic
// for five sines and cosines, the products, the 32-step square root, the
// unrolled vectoring cordic for both arctangents and the scaling, and each
// result then passes through the output buffer to the master side. A new
// pair is taken every cycle while the pipeline is not held; a two-entry
// output buffer keeps the input side open while a result waits, and when
// that buffer is full and the sink stalls the whole pipeline holds.
// ----------------------------------------------------------------------------
`default_nettype none

module great_circle_distance_bearing_core
  import gcdb_pkg::*;
#(
  parameter int FRAC_BITS    = FRAC_BITS_DEF,
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // start_lat[29:0], start_lon[60:30], dest_lat[90:61], dest_lon[121:91]
  input  wire logic [127:0] s_tdata,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // distance_m[24:0], bearing_deg[49:25], bearing_code[57:50]
  output logic [63:0]       m_tdata
);

  localparam int LAT = 5 + CORDIC_STEPS + 6 + SQRT_STEPS + 1 + CORDIC_STEPS + 3;

  logic           en;
  logic [LAT-1:0] vpipe;
  logic           push, pop;
  logic [1:0]     cnt;
  res_t           fifo0, fifo1, res;

  function automatic logic signed [AW-1:0] to_rad(input logic signed [31:0] d);
    logic signed [59:0] p;
    p = 60'(d) * 60'(DEG2RAD_Q);
    return AW'(p >>> (FRAC_BITS + 2));
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe <= '0;
    end else if (en) begin
      vpipe <= {vpipe[LAT-2:0], s_tvalid};
    end
  end

  // s1: coordinate differences
  logic signed [29:0] slat1, dlat1;
  logic signed [30:0] dphi1;
  logic signed [31:0] dlam1;
  always_ff @(posedge clk) begin
    if (en) begin
      slat1 <= s_tdata[29:0];
      dlat1 <= s_tdata[90:61];
      dphi1 <= 31'($signed(s_tdata[90:61])) - 31'($signed(s_tdata[29:0]));
      dlam1 <= 32'($signed(s_tdata[121:91])) - 32'($signed(s_tdata[60:30]));
    end
  end

  // s2: degrees to q30 radians
  logic signed [AW-1:0] rphi2, rlam2, rlats2, rlatd2;
  always_ff @(posedge clk) begin
    if (en) begin
      rphi2  <= to_rad(32'(dphi1));
      rlam2  <= to_rad(dlam1);
      rlats2 <= to_rad(32'(slat1));
      rlatd2 <= to_rad(32'(dlat1));
    end
  end

  // s3..s5: five lanes (half dphi, half dlam, lat start, lat dest, dlam)
  logic signed [AW-1:0] ang [5];
  logic signed [AW-1:0] ang3 [5];
  logic signed [AW-1:0] ang4 [5];
  logic signed [CW-1:0] ang5 [5];
  logic                 neg5 [5];
  logic signed [CW-1:0] rx [5];
  logic signed [CW-1:0] ry [5];
  logic signed [CW-1:0] rz [5];
  logic                 rneg [5];

  assign ang[0] = rphi2 >>> 1;
  assign ang[1] = rlam2 >>> 1;
  assign ang[2] = rlats2;
  assign ang[3] = rlatd2;
  assign ang[4] = rlam2;

  for (genvar l = 0; l < 5; l++) begin : g_rot
    always_ff @(posedge clk) begin
      if (en) begin
        // truncating remainder by a full turn
        if (ang[l] >= FOUR_PI_Q) ang3[l] <= ang[l] - FOUR_PI_Q;
        else if (ang[l] >= TWO_PI_Q) ang3[l] <= ang[l] - TWO_PI_Q;
        else if (ang[l] <= -FOUR_PI_Q) ang3[l] <= ang[l] + FOUR_PI_Q;
        else if (ang[l] <= -TWO_PI_Q) ang3[l] <= ang[l] + TWO_PI_Q;
        else ang3[l] <= ang[l];

        if (ang3[l] > PI_Q) ang4[l] <= ang3[l] - TWO_PI_Q;
        else if (ang3[l] < -PI_Q) ang4[l] <= ang3[l] + TWO_PI_Q;
        else ang4[l] <= ang3[l];

        // fold into the right half plane, results negated later
        if (ang4[l] > HALF_PI_Q) begin
          ang5[l] <= CW'(ang4[l] - PI_Q);
          neg5[l] <= 1'b1;
        end else if (ang4[l] < -HALF_PI_Q) begin
          ang5[l] <= CW'(ang4[l] + PI_Q);
          neg5[l] <= 1'b1;
        end else begin
          ang5[l] <= CW'(ang4[l]);
          neg5[l] <= 1'b0;
        end
      end
    end

    gcdb_cordic #(
      .W(CW), .STEPS(CORDIC_STEPS), .VECTORING(1'b0), .SW(1)
    ) u_rot (
      .clk(clk), .en(en),
      .x_in(GAIN_K), .y_in('0), .z_in(ang5[l]), .side_in(neg5[l]),
      .x_out(rx[l]), .y_out(ry[l]), .z_out(rz[l]), .side_out(rneg[l])
    );
  end

  // p1: apply fold sign
  logic signed [QW-1:0] sn [5];
  logic signed [QW-1:0] cs [5];
  for (genvar l = 0; l < 5; l++) begin : g_sign
    always_ff @(posedge clk) begin
      if (en) begin
        sn[l] <= rneg[l] ? QW'(-ry[l]) : QW'(ry[l]);
        cs[l] <= rneg[l] ? QW'(-rx[l]) : QW'(rx[l]);
      end
    end
  end

  // m1..m4: haversine term and bearing vector
  logic signed [QW-1:0] ps1_1, ps2_1, yb1, tcs1, tss1, cs1, cd1, cl1;
  logic signed [QW-1:0] ps1_2, q2, u2, cd2, yb2, tcs2;
  logic signed [QW-1:0] ps1_3, r3, xb3, yb3;
  logic [30:0]          a4;
  logic signed [QW-1:0] xb4, yb4;
  logic signed [QW:0]   asum;
  always_comb asum = (QW+1)'(ps1_3) + (QW+1)'(r3);

  always_ff @(posedge clk) begin
    if (en) begin
      ps1_1 <= mulq(sn[0], sn[0]);
      ps2_1 <= mulq(sn[1], sn[1]);
      yb1   <= mulq(sn[4], cs[3]);
      tcs1  <= mulq(cs[2], sn[3]);
      tss1  <= mulq(sn[2], cs[3]);
      cs1   <= cs[2];
      cd1   <= cs[3];
      cl1   <= cs[4];

      ps1_2 <= ps1_1;
      q2    <= mulq(ps2_1, cs1);
      u2    <= mulq(tss1, cl1);
      cd2   <= cd1;
      yb2   <= yb1;
      tcs2  <= tcs1;

      ps1_3 <= ps1_2;
      r3    <= mulq(q2, cd2);
      xb3   <= tcs2 - u2;
      yb3   <= yb2;

      if (asum < 0) a4 <= '0;
      else if (asum > (QW+1)'(ONE_Q)) a4 <= ONE_Q;
      else a4 <= 31'(asum);
      xb4 <= xb3;
      yb4 <= yb3;
    end
  end

  // m5 and square roots: lane 0 of a, lane 1 of 1 - a
  logic [SQW-1:0]       rem_r  [2][SQRT_STEPS+1];
  logic [SQW-1:0]       root_r [2][SQRT_STEPS+1];
  logic signed [QW-1:0] xd [SQRT_STEPS+1];
  logic signed [QW-1:0] yd [SQRT_STEPS+1];

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0][0]  <= SQW'(a4) << 30;
      rem_r[1][0]  <= SQW'(ONE_Q - a4) << 30;
      root_r[0][0] <= '0;
      root_r[1][0] <= '0;
      xd[0]        <= xb4;
      yd[0]        <= yb4;
    end
  end

  for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
    localparam logic [SQW-1:0] BITV = SQW'(1) << (2 * (SQRT_STEPS - 1 - j));
    always_ff @(posedge clk) begin
      if (en) begin
        xd[j+1] <= xd[j];
        yd[j+1] <= yd[j];
      end
    end
    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [SQW-1:0] trial;
      assign trial = root_r[l][j] + BITV;
      always_ff @(posedge clk) begin
        if (en) begin
          if (rem_r[l][j] >= trial) begin
            rem_r[l][j+1]  <= rem_r[l][j] - trial;
            root_r[l][j+1] <= (root_r[l][j] >> 1) + BITV;
          end else begin
            rem_r[l][j+1]  <= rem_r[l][j];
            root_r[l][j+1] <= root_r[l][j] >> 1;
          end
        end
      end
    end
  end

  // a0: atan2 set-up, lane 0 central angle, lane 1 bearing
  logic signed [CW-1:0] vy [2];
  logic signed [CW-1:0] vx [2];
  logic signed [CW-1:0] ay [2];
  logic signed [CW-1:0] ax [2];
  logic signed [CW-1:0] az [2];
  logic                 azero [2];
  logic signed [CW-1:0] ox [2];
  logic signed [CW-1:0] oy [2];
  logic signed [CW-1:0] oz [2];
  logic                 ozero [2];

  assign vy[0] = CW'(root_r[0][SQRT_STEPS]);
  assign vx[0] = CW'(root_r[1][SQRT_STEPS]);
  assign vy[1] = CW'(yd[SQRT_STEPS]);
  assign vx[1] = CW'(xd[SQRT_STEPS]);

  for (genvar l = 0; l < 2; l++) begin : g_vec
    always_ff @(posedge clk) begin
      if (en) begin
        azero[l] <= (vx[l] == '0) && (vy[l] == '0);
        if (vx[l] < 0) begin
          az[l] <= vy[l][CW-1] ? -PI_C : PI_C;
          ax[l] <= -vx[l];
          ay[l] <= -vy[l];
        end else begin
          az[l] <= '0;
          ax[l] <= vx[l];
          ay[l] <= vy[l];
        end
      end
    end

    gcdb_cordic #(
      .W(CW), .STEPS(CORDIC_STEPS), .VECTORING(1'b1), .SW(1)
    ) u_vec (
      .clk(clk), .en(en),
      .x_in(ax[l]), .y_in(ay[l]), .z_in(az[l]), .side_in(azero[l]),
      .x_out(ox[l]), .y_out(oy[l]), .z_out(oz[l]), .side_out(ozero[l])
    );
  end

  // f1..f3: scaling, saturation, byte code
  logic signed [CW:0]      c2;
  logic signed [CW-1:0]    brng;
  logic signed [CW+24:0]   pc1;
  logic signed [CW+30:0]   pb1;
  logic signed [CW+24:0]   dsh;
  logic signed [CW+30:0]   bsh;
  logic [24:0]             dist2;
  logic signed [24:0]      deg2;

  always_comb begin
    c2   = ozero[0] ? '0 : {oz[0], 1'b0};
    brng = ozero[1] ? '0 : oz[1];
    dsh  = pc1 >>> 30;
    bsh  = pb1 >>> 38;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pc1 <= (c2 < 0) ? '0 : (CW+25)'(c2) * (CW+25)'(EARTH_R_M);
      pb1 <= (CW+31)'(brng) * (CW+31)'(RAD2DEG_Q);

      dist2 <= (dsh > (CW+25)'(DIST_MAX)) ? DIST_MAX : 25'(dsh);
      if (bsh > (CW+31)'(BRG_MAX)) deg2 <= BRG_MAX;
      else if (bsh < -(CW+31)'(BRG_MAX)) deg2 <= -BRG_MAX;
      else deg2 <= 25'(bsh);

      res.distance_m   <= dist2;
      res.bearing_deg  <= deg2;
      res.bearing_code <= code_of(deg2);
    end
  end

  // two-entry output buffer
  assign pop      = m_tvalid && m_tready;
  assign en       = (cnt != 2'd2) || m_tready;
  assign push     = vpipe[LAT-1] && en;
  assign s_tready = en;
  assign m_tvalid = cnt != 2'd0;
  assign m_tdata  = {6'd0, fifo0};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else begin
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      fifo0 <= (cnt == 2'd2) ? fifo1 : res;
      if (push && cnt == 2'd2) fifo1 <= res;
    end else if (push) begin
      if (cnt == 2'd0) fifo0 <= res;
      else fifo1 <= res;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt != 2'd3)
    else $error("output buffer count out of range");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (vpipe[LAT-1] && en && !pop) |-> (cnt != 2'd2))
    else $error("result pushed into a full output buffer");

  a_dist_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (fifo0.distance_m <= DIST_MAX))
    else $error("distance above saturation limit");

  a_brg_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((fifo0.bearing_deg <= BRG_MAX) && (fifo0.bearing_deg >= -BRG_MAX)))
    else $error("bearing outside half-turn range");

endmodule

`default_nettype wire

### tb/great_circle_distance_bearing_core_test.sv
// ----------------------------------------------------------------------------
// great_circle_distance_bearing_core_test
// checks distance, bearing and bearing code against a fixed-point predictor
// ----------------------------------------------------------------------------
// Sends directed coordinate pairs and then random ones, both near each other
// and anywhere on or off the valid range. Both sides stall in short random
// bursts until a final calm stretch. Every result is compared with the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module great_circle_distance_bearing_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import gcdb_pkg::*;

  localparam int STEPS = CORDIC_STEPS_DEF;
  localparam longint PI_L = 64'sd3373259426;
  localparam longint HALF_PI_L = 64'sd1686629713;
  localparam longint TWO_PI_L = 64'sd6746518852;
  localparam longint ONE_L = 64'sd1073741824;

  typedef struct {
    logic [24:0] distance_m;
    logic [24:0] bearing_deg;
    logic [7:0]  bearing_code;
  } route_t;

  function automatic longint qmul(longint a, longint b);
    return (a * b) >>> 30;
  endfunction

  function automatic longint arctan_step(int i);
    return longint'(ATAN_TAB[i]);
  endfunction

  function automatic void rotate(input longint th, output longint sn, output longint cs);
    longint r, x, y, z, dx, dy;
    bit neg;
    r = th % TWO_PI_L;
    x = 64'sd652032874; y = 0; neg = 0;
    if (r > PI_L) r -= TWO_PI_L;
    else if (r < -PI_L) r += TWO_PI_L;
    if (r > HALF_PI_L) begin r -= PI_L; neg = 1; end
    else if (r < -HALF_PI_L) begin r += PI_L; neg = 1; end
    z = r;
    for (int i = 0; i < STEPS && i < 32; i++) begin
      dx = y >>> i; dy = x >>> i;
      if (z >= 0) begin x -= dx; y += dy; z -= arctan_step(i); end
      else begin x += dx; y -= dy; z += arctan_step(i); end
    end
    sn = neg ? -y : y;
    cs = neg ? -x : x;
  endfunction

  function automatic longint angle_of(longint y, longint x);
    longint z, dx, dy;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      z = (y >= 0) ? PI_L : -PI_L;
      x = -x; y = -y;
    end
    for (int i = 0; i < STEPS && i < 32; i++) begin
      dx = y >>> i; dy = x >>> i;
      if (y >= 0) begin x += dx; y -= dy; z += arctan_step(i); end
      else begin x -= dx; y += dy; z -= arctan_step(i); end
    end
    return z;
  endfunction

  function automatic longint int_root(longint v);
    logic [63:0] rem, root, b;
    rem = 64'(v) << 30; root = 0;
    for (int k = 31; k >= 0; k--) begin
      b = 64'd1 << (2 * k);
      if (rem >= root + b) begin
        rem -= root + b;
        root = (root >> 1) + b;
      end else begin
        root = root >> 1;
      end
    end
    return longint'(root);
  endfunction

  function automatic longint deg_to_rad(longint d);
    return (d * 64'sd74961321) >>> (FRAC_BITS_DEF + 2);
  endfunction

  function automatic void predict_route(input logic [127:0] pt, output route_t r);
    longint slat, slon, dlat, dlon, ls, ld, dphi, dlam;
    longint s1, c1, s2, c2, ss, cs, sd, cd, sl, cl;
    longint a, c, range_m, y, x, brng, deg, whole, code;
    slat = longint'($signed(pt[29:0]));
    slon = longint'($signed(pt[60:30]));
    dlat = longint'($signed(pt[90:61]));
    dlon = longint'($signed(pt[121:91]));
    ls = deg_to_rad(slat); ld = deg_to_rad(dlat);
    dphi = deg_to_rad(dlat - slat); dlam = deg_to_rad(dlon - slon);
    rotate(dphi >>> 1, s1, c1);
    rotate(dlam >>> 1, s2, c2);
    rotate(ls, ss, cs);
    rotate(ld, sd, cd);
    rotate(dlam, sl, cl);
    a = qmul(s1, s1) + qmul(qmul(qmul(s2, s2), cs), cd);
    if (a < 0) a = 0;
    if (a > ONE_L) a = ONE_L;
    c = 2 * angle_of(int_root(a), int_root(ONE_L - a));
    if (c < 0) c = 0;
    range_m = (c * 64'sd6371100) >>> 30;
    if (range_m > 20015400) range_m = 20015400;
    y = qmul(sl, cd);
    x = qmul(cs, sd) - qmul(qmul(ss, cd), cl);
    brng = angle_of(y, x);
    deg = (brng * 64'sd961263669) >>> 38;
    if (deg > 11796480) deg = 11796480;
    if (deg < -11796480) deg = -11796480;
    if (deg < 0) begin
      whole = (-deg) >> 16;
      code = 255 - (128 * whole) / 180;
    end else begin
      whole = deg >> 16;
      code = (128 * whole) / 180;
    end
    r.distance_m = 25'(range_m);
    r.bearing_deg = 25'(deg);
    r.bearing_code = 8'(code);
  endfunction

  class route_board;
    route_t pending[$];
    int errors;
    int checked;

    function void note_pair(logic [127:0] pt);
      route_t r;
      predict_route(pt, r);
      pending.push_back(r);
    endfunction

    function void check_result(logic [63:0] d);
      route_t e;
      if (pending.size() == 0) begin
        $display("%0t unexpected result %h", $realtime, d);
        errors++;
        return;
      end
      e = pending.pop_front();
      checked++;
      if (d[24:0] !== e.distance_m) begin
        $display("%0t distance_m expected %0d actual %0d", $realtime, e.distance_m, d[24:0]);
        errors++;
      end
      if (d[49:25] !== e.bearing_deg) begin
        $display("%0t bearing_deg expected %0d actual %0d", $realtime,
                 $signed(e.bearing_deg), $signed(d[49:25]));
        errors++;
      end
      if (d[57:50] !== e.bearing_code) begin
        $display("%0t bearing_code expected %0d actual %0d", $realtime,
                 e.bearing_code, d[57:50]);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic s_tvalid = 0;
  logic s_tready;
  logic [127:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 0;
  logic [63:0] m_tdata;
  bit calm = 0;
  route_board board = new();

  always #5 clk = ~clk;

  great_circle_distance_bearing_core u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) board.check_result(m_tdata);
  end

  // sink stalls in bursts
  initial begin
    int hold;
    @(negedge clk);
    forever begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        hold = $urandom_range(1, 3);
        m_tready <= 0;
        repeat (hold) @(negedge clk);
      end
      m_tready <= 1;
      @(negedge clk);
    end
  end

  localparam int LAT_MAX = 377487360;
  localparam int LON_MAX = 754974720;

  function automatic logic [127:0] pack_pair(int slat, int slon, int dlat, int dlon);
    logic [127:0] v;
    v = '0;
    v[29:0] = 30'(slat);
    v[60:30] = 31'(slon);
    v[90:61] = 30'(dlat);
    v[121:91] = 31'(dlon);
    return v;
  endfunction

  function automatic int rand_span(int lim);
    return int'($urandom_range(0, 2 * lim)) - lim;
  endfunction

  task automatic send_pair(input logic [127:0] v);
    if (!calm && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    s_tvalid <= 1;
    s_tdata <= v;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    board.note_pair(v);
    @(negedge clk);
  endtask

  task automatic idle_source();
    s_tvalid <= 0;
    @(negedge clk);
  endtask

  task automatic drain();
    while (board.pending.size() != 0) @(negedge clk);
  endtask

  function automatic logic [127:0] random_pair(int mode);
    int a, b;
    case (mode)
      0: begin
        a = rand_span(LAT_MAX); b = rand_span(LON_MAX);
        return pack_pair(a, b, a + rand_span(1 << 22), b + rand_span(1 << 22));
      end
      1: return pack_pair(rand_span(LAT_MAX), rand_span(LON_MAX),
                          rand_span(LAT_MAX), rand_span(LON_MAX));
      2: begin
        a = rand_span(LAT_MAX); b = rand_span(LON_MAX);
        return pack_pair(a, b, -a + rand_span(8), b + LON_MAX + rand_span(8));
      end
      default: return {6'd0, 122'({$urandom, $urandom, $urandom, $urandom})};
    endcase
  endfunction

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    // directed: range extremes, same point, poles, antipodes, raw extremes
    send_pair(pack_pair(0, 0, 0, 0));
    send_pair(pack_pair(LAT_MAX, LON_MAX, LAT_MAX, LON_MAX));
    send_pair(pack_pair(-LAT_MAX, -LON_MAX, LAT_MAX, LON_MAX));
    send_pair(pack_pair(LAT_MAX, 0, -LAT_MAX, 0));
    send_pair(pack_pair(0, 0, 0, LON_MAX));
    send_pair(pack_pair(0, -LON_MAX, 0, LON_MAX));
    send_pair(pack_pair(0, 0, 0, 1));
    send_pair(pack_pair(0, 0, 0, -1));
    send_pair(pack_pair(0, 0, 1, 0));
    send_pair(pack_pair(0, 0, -1, 0));
    send_pair(pack_pair(0, 0, -1, -1));
    send_pair(pack_pair(0, 0, -1, 1));
    send_pair(pack_pair(LAT_MAX, 0, LAT_MAX, LON_MAX));
    send_pair(pack_pair(-LAT_MAX, LON_MAX, 0, -LON_MAX));
    send_pair(pack_pair(-(1 << 29), -(1 << 30), -(1 << 29), -(1 << 30)));
    send_pair(pack_pair((1 << 29) - 1, (1 << 30) - 1, (1 << 29) - 1, (1 << 30) - 1));
    send_pair(pack_pair(-(1 << 29), (1 << 30) - 1, (1 << 29) - 1, -(1 << 30)));
    send_pair(pack_pair(12345678, -98765432, -23456789, 87654321));
    send_pair(pack_pair(LAT_MAX / 2, 0, 0, LON_MAX / 2));
    send_pair(pack_pair(0, 0, -LAT_MAX / 3, -LON_MAX / 2));
    idle_source();
    drain();
    for (int i = 0; i < 1100; i++) begin
      if (i == 500) begin
        idle_source();
        drain();
      end
      if (i == 900) calm = 1;
      send_pair(random_pair($urandom_range(0, 3)));
    end
    idle_source();
    drain();
    repeat (200) @(negedge clk);
    $display("covered directed extremes, poles, antipodes and %0d checked routes",
             board.checked);
    $display("random pairs near, far, near-antipodal and raw bits, with stalls on both sides");
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("status: fail");
    $finish;
  end

endmodule

`default_nettype wire
